// File: design/twbf_pkg.sv
package twbf_pkg;

   localparam int CompBits    = 16;
   localparam int WeightBits  = 16;
   localparam int FloorBits   = 15;
   localparam int MulBits     = (CompBits > WeightBits) ? CompBits : WeightBits;
   localparam int ProdBits    = 2 * MulBits;
   localparam int DivDenBits  = 2 * CompBits;
   localparam int DivNumBits  = ProdBits + DivDenBits;
   localparam int RootBits    = CompBits + 1;
   localparam int SqrtInBits  = 2 * RootBits;
   localparam int SqrtRemBits = RootBits + 2;

   typedef logic [1:0] opcode_type;
   localparam opcode_type OpScent  = 2'd0;
   localparam opcode_type OpVision = 2'd1;
   localparam opcode_type OpTrust  = 2'd2;
   localparam opcode_type OpTick   = 2'd3;

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CsrFloor    = 2'd0;
   localparam csr_index_type CsrPassthru = 2'd1;
   localparam csr_index_type CsrRenorm   = 2'd2;

   typedef logic signed [CompBits-1:0] comp_type;

   // start pulse toward a serial unit, done pulse back
   typedef struct packed {
      logic start;
   } unit_req_type;

   typedef struct packed {
      logic done;
   } unit_rsp_type;

   function automatic logic [MulBits-1:0] mag_of(input comp_type v);
      logic [CompBits-1:0] m;
      m = v[CompBits-1] ? (~v + 1'b1) : v;
      return MulBits'(m);
   endfunction

endpackage

// File: design/twbf_mul.sv
module twbf_mul (
   input  logic                            clock,
   input  logic                            reset,
   input  twbf_pkg::unit_req_type          ctl,
   input  logic [twbf_pkg::MulBits-1:0]    a,
   input  logic [twbf_pkg::MulBits-1:0]    b,
   output twbf_pkg::unit_rsp_type          sts,
   output logic [twbf_pkg::ProdBits-1:0]   prod
);
   import twbf_pkg::*;

   localparam int CntBits = $clog2(MulBits);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CntBits-1:0]  cnt_ff, cnt_in;
   logic [ProdBits-1:0] acc_ff, acc_in;
   logic [ProdBits-1:0] mcand_ff, mcand_in;
   logic [MulBits-1:0]  mplier_ff, mplier_in;

   // one multiplier bit per cycle: add shifted multiplicand when the bit is set
   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      if (ctl.start) begin
         busy_in   = 1'b1;
         cnt_in    = CntBits'(MulBits - 1);
         acc_in    = '0;
         mcand_in  = ProdBits'(a);
         mplier_in = b;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = {mcand_ff[ProdBits-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[MulBits-1:1]};
         cnt_in    = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff    <= cnt_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign sts.done = done_ff;
   assign prod     = acc_ff;

endmodule

// File: design/twbf_div.sv
module twbf_div (
   input  logic                              clock,
   input  logic                              reset,
   input  twbf_pkg::unit_req_type            ctl,
   input  logic [twbf_pkg::DivNumBits-1:0]   num,
   input  logic [twbf_pkg::DivDenBits-1:0]   den,
   output twbf_pkg::unit_rsp_type            sts,
   output logic [twbf_pkg::DivNumBits-1:0]   quo
);
   import twbf_pkg::*;

   localparam int CntBits = $clog2(DivNumBits);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CntBits-1:0]    cnt_ff, cnt_in;
   logic [DivNumBits-1:0] sh_ff, sh_in;
   logic [DivDenBits-1:0] den_ff, den_in;
   logic [DivDenBits-1:0] rem_ff, rem_in;
   logic [DivDenBits:0]   trial;
   logic                  qbit;

   // restoring division, one quotient bit per cycle shifted into the dividend register
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      sh_in   = sh_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, sh_ff[DivNumBits-1]};
      qbit    = trial >= {1'b0, den_ff};
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = CntBits'(DivNumBits - 1);
         sh_in   = num;
         den_in  = den;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = qbit ? DivDenBits'(trial - {1'b0, den_ff}) : trial[DivDenBits-1:0];
         sh_in  = {sh_ff[DivNumBits-2:0], qbit};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      sh_ff  <= sh_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign sts.done = done_ff;
   assign quo      = sh_ff;

endmodule

// File: design/twbf_sqrt.sv
module twbf_sqrt (
   input  logic                              clock,
   input  logic                              reset,
   input  twbf_pkg::unit_req_type            ctl,
   input  logic [twbf_pkg::SqrtInBits-1:0]   x,
   output twbf_pkg::unit_rsp_type            sts,
   output logic [twbf_pkg::RootBits-1:0]     root
);
   import twbf_pkg::*;

   localparam int CntBits = $clog2(RootBits);
   localparam int WideBits = SqrtRemBits + 2;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CntBits-1:0]     cnt_ff, cnt_in;
   logic [SqrtInBits-1:0]  xs_ff, xs_in;
   logic [SqrtRemBits-1:0] rem_ff, rem_in;
   logic [RootBits-1:0]    root_ff, root_in;
   logic [WideBits-1:0]    rn;
   logic [WideBits-1:0]    trial;
   logic                   ge;

   // digit-by-digit square root: two radicand bits in, one root bit out per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      xs_in   = xs_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      rn      = {rem_ff, xs_ff[SqrtInBits-1:SqrtInBits-2]};
      trial   = WideBits'({root_ff, 2'b01});
      ge      = rn >= trial;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = CntBits'(RootBits - 1);
         xs_in   = x;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? SqrtRemBits'(rn - trial) : rn[SqrtRemBits-1:0];
         root_in = {root_ff[RootBits-2:0], ge};
         xs_in   = {xs_ff[SqrtInBits-3:0], 2'b00};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      xs_ff   <= xs_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign sts.done = done_ff;
   assign root     = root_ff;

endmodule

// File: design/trust_weighted_bearing_fusion_core.sv
// Sample and trust-update beats produce no result.
// A tick runs the fallback path, the weighted path or the weighted path with
// renormalizing on a bit-serial multiplier, a 64-step divider and a 17-step
// square root, shared by one sequencer; one item is worked at a time.
// Reset (synchronous, active high) clears stored bearings and weights and loads
// floor 3, passthrough on and renormalize on; no result is pending after reset.
module trust_weighted_bearing_fusion_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  twbf_pkg::opcode_type              req_opcode,
   input  logic signed [15:0]                req_bearing_x,
   input  logic signed [15:0]                req_bearing_y,
   input  logic signed [15:0]                req_proximity,
   input  logic                              req_proximity_present,
   input  logic [15:0]                       req_scent_weight,
   input  logic [15:0]                       req_vision_weight,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [15:0]                rsp_fused_x,
   output logic signed [15:0]                rsp_fused_y,
   output logic signed [15:0]                rsp_fused_proximity,
   output logic                              rsp_proximity_valid,
   output logic [15:0]                       rsp_scent_weight_used,
   output logic [15:0]                       rsp_vision_weight_used,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  twbf_pkg::csr_index_type           csr_index,
   input  logic [twbf_pkg::FloorBits-1:0]    csr_data
);
   import twbf_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ISSUE = 4'b0010,
      ST_WAIT  = 4'b0100,
      ST_HOLD  = 4'b1000
   } state_type;

   // sequencer steps of a tick
   typedef logic [3:0] step_type;
   localparam step_type StSxx    = 4'd0;
   localparam step_type StSyy    = 4'd1;
   localparam step_type StVxx    = 4'd2;
   localparam step_type StVyy    = 4'd3;
   localparam step_type StFll    = 4'd4;
   localparam step_type StDecide = 4'd5;
   localparam step_type StPw1    = 4'd6;
   localparam step_type StPw2    = 4'd7;
   localparam step_type StDw     = 4'd8;
   localparam step_type StRn     = 4'd9;
   localparam step_type StQx     = 4'd10;
   localparam step_type StQy     = 4'd11;
   localparam step_type StUd     = 4'd12;
   localparam step_type StUr     = 4'd13;

   localparam int SqBits  = ProdBits + 1;
   localparam int DenBits = WeightBits + 1;
   localparam int NumBits = ProdBits + 2;
   localparam logic [RootBits-1:0] UnitOne = RootBits'(1) << (CompBits - 1);
   localparam comp_type CompMax = comp_type'((RootBits'(1) << (CompBits - 1)) - 1'b1);
   localparam comp_type CompMin = comp_type'(RootBits'(1) << (CompBits - 1));

   // saturate a rounded weighted-average magnitude with its sign
   function automatic comp_type wsat(input logic [DivNumBits-1:0] q, input logic neg);
      comp_type r;
      if (neg) begin
         r = (q >= DivNumBits'(UnitOne)) ? CompMin : comp_type'(~q[CompBits-1:0] + 1'b1);
      end else begin
         r = (q >= DivNumBits'(UnitOne)) ? CompMax : comp_type'(q[CompBits-1:0]);
      end
      return r;
   endfunction

   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   logic [1:0] ax_ff, ax_in;

   // configuration
   logic [FloorBits-1:0] floor_ff, floor_in;
   logic                 passthru_ff, passthru_in;
   logic                 renorm_ff, renorm_in;

   // stored sources
   comp_type sx_ff, sx_in, sy_ff, sy_in, sp_ff, sp_in;
   comp_type vx_ff, vx_in, vy_ff, vy_in, vp_ff, vp_in;
   logic     spf_ff, spf_in, vpf_ff, vpf_in;
   logic [WeightBits-1:0] ts_ff, ts_in, tv_ff, tv_in;

   // tick working registers
   logic [SqBits-1:0]     ssq_ff, ssq_in, vsq_ff, vsq_in;
   logic [ProdBits-1:0]   flsq_ff, flsq_in;
   logic [WeightBits-1:0] ws_ff, ws_in, wv_ff, wv_in;
   logic [DenBits-1:0]    den_ff, den_in;
   logic                  pv_ff, pv_in;
   logic [ProdBits-1:0]   p1_ff, p1_in;
   logic [NumBits-2:0]    nmag_ff, nmag_in;
   logic                  nneg_ff, nneg_in;
   comp_type              fx_ff, fx_in, fy_ff, fy_in, fp_ff, fp_in;
   logic [ProdBits-1:0]   fxsq_ff, fxsq_in, fysq_ff, fysq_in;
   logic [DivDenBits-1:0] s_ff, s_in;
   logic [SqrtInBits-1:0] d_ff, d_in;

   // result register
   logic     rv_ff, rv_in;
   comp_type ox_ff, ox_in, oy_ff, oy_in, op_ff, op_in;
   logic     opv_ff, opv_in;
   logic [WeightBits-1:0] ows_ff, ows_in, owv_ff, owv_in;

   // serial units
   unit_req_type          mul_req, div_req, sqrt_req;
   unit_rsp_type          mul_rsp, div_rsp, sqrt_rsp;
   logic [MulBits-1:0]    mul_a, mul_b;
   logic [ProdBits-1:0]   mul_prod;
   logic [DivNumBits-1:0] div_num, div_quo;
   logic [DivDenBits-1:0] div_den;
   logic [RootBits-1:0]   sqrt_root;
   logic                  unit_done;

   comp_type              scomp, vcomp;
   logic                  gate_s, gate_v;
   logic [WeightBits-1:0] ws_w, wv_w;
   logic [DenBits-1:0]    den_w;
   logic signed [NumBits-1:0] num_w;
   logic [NumBits-1:0]    nabs_w;
   logic [DivDenBits:0]   s_w;
   logic [RootBits:0]     rinc_w;
   logic [RootBits-1:0]   r_w;
   logic                  rneg_w;
   comp_type              rsat_w;

   twbf_mul u_mul (
      .clock (clock),
      .reset (reset),
      .ctl   (mul_req),
      .a     (mul_a),
      .b     (mul_b),
      .sts   (mul_rsp),
      .prod  (mul_prod)
   );

   twbf_div u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_req),
      .num   (div_num),
      .den   (div_den),
      .sts   (div_rsp),
      .quo   (div_quo)
   );

   twbf_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .ctl   (sqrt_req),
      .x     (d_ff),
      .sts   (sqrt_rsp),
      .root  (sqrt_root)
   );

   assign unit_done = mul_rsp.done | div_rsp.done | sqrt_rsp.done;

   // component under work for the weighted average: x, y, then proximity
   always_comb begin
      case (ax_ff)
         2'd0:    begin scomp = sx_ff; vcomp = vx_ff; end
         2'd1:    begin scomp = sy_ff; vcomp = vy_ff; end
         default: begin scomp = sp_ff; vcomp = vp_ff; end
      endcase
   end

   // gating: a source below the floor loses its weight
   assign gate_s = ssq_ff < SqBits'(flsq_ff);
   assign gate_v = vsq_ff < SqBits'(flsq_ff);
   assign ws_w   = gate_s ? '0 : ts_ff;
   assign wv_w   = gate_v ? '0 : tv_ff;
   assign den_w  = DenBits'(ws_w) + DenBits'(wv_w);

   // signed weighted sum from the two magnitude products
   assign num_w  = (scomp[CompBits-1] ? -$signed(NumBits'(p1_ff)) : $signed(NumBits'(p1_ff)))
                 + (vcomp[CompBits-1] ? -$signed(NumBits'(mul_prod))
                                      : $signed(NumBits'(mul_prod)));
   assign nabs_w = num_w[NumBits-1] ? NumBits'(-num_w) : NumBits'(num_w);
   assign s_w    = (DivDenBits+1)'(fxsq_ff) + (DivDenBits+1)'(mul_prod);

   // unit scaling: r = (isqrt + 1) / 2, capped at one
   assign rinc_w = (RootBits+1)'(sqrt_root) + 1'b1;
   assign r_w    = (rinc_w[RootBits:1] > UnitOne) ? UnitOne : rinc_w[RootBits:1];
   assign rneg_w = ax_ff[0] ? fy_ff[CompBits-1] : fx_ff[CompBits-1];
   always_comb begin
      if (rneg_w) begin
         rsat_w = (r_w == UnitOne) ? CompMin : comp_type'(~r_w[CompBits-1:0] + 1'b1);
      end else begin
         rsat_w = (r_w == UnitOne) ? CompMax : comp_type'(r_w[CompBits-1:0]);
      end
   end

   // unit launch and operand selection
   always_comb begin
      mul_req.start  = 1'b0;
      div_req.start  = 1'b0;
      sqrt_req.start = 1'b0;
      mul_a   = mag_of(sx_ff);
      mul_b   = mag_of(sx_ff);
      div_num = DivNumBits'(NumBits'(nmag_ff) + NumBits'(den_ff >> 1));
      div_den = DivDenBits'(den_ff);
      case (step_ff)
         StSxx: begin
            mul_a = mag_of(sx_ff);
            mul_b = mag_of(sx_ff);
         end
         StSyy: begin
            mul_a = mag_of(sy_ff);
            mul_b = mag_of(sy_ff);
         end
         StVxx: begin
            mul_a = mag_of(vx_ff);
            mul_b = mag_of(vx_ff);
         end
         StVyy: begin
            mul_a = mag_of(vy_ff);
            mul_b = mag_of(vy_ff);
         end
         StFll: begin
            mul_a = MulBits'(floor_ff);
            mul_b = MulBits'(floor_ff);
         end
         StPw1: begin
            mul_a = MulBits'(ws_ff);
            mul_b = mag_of(scomp);
         end
         StPw2: begin
            mul_a = MulBits'(wv_ff);
            mul_b = mag_of(vcomp);
         end
         StQx: begin
            mul_a = mag_of(fx_ff);
            mul_b = mag_of(fx_ff);
         end
         StQy: begin
            mul_a = mag_of(fy_ff);
            mul_b = mag_of(fy_ff);
         end
         StUd: begin
            div_num = {(ax_ff[0] ? fysq_ff : fxsq_ff), {DivDenBits{1'b0}}};
            div_den = s_ff;
         end
         default: begin
         end
      endcase
      if (state_ff == ST_ISSUE) begin
         case (step_ff)
            StSxx, StSyy, StVxx, StVyy, StFll, StPw1, StPw2, StQx, StQy: begin
               mul_req.start = 1'b1;
            end
            StDw, StUd: begin
               div_req.start = 1'b1;
            end
            StUr: begin
               sqrt_req.start = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      ax_in       = ax_ff;
      floor_in    = floor_ff;
      passthru_in = passthru_ff;
      renorm_in   = renorm_ff;
      sx_in = sx_ff; sy_in = sy_ff; sp_in = sp_ff; spf_in = spf_ff;
      vx_in = vx_ff; vy_in = vy_ff; vp_in = vp_ff; vpf_in = vpf_ff;
      ts_in = ts_ff; tv_in = tv_ff;
      ssq_in  = ssq_ff;
      vsq_in  = vsq_ff;
      flsq_in = flsq_ff;
      ws_in   = ws_ff;
      wv_in   = wv_ff;
      den_in  = den_ff;
      pv_in   = pv_ff;
      p1_in   = p1_ff;
      nmag_in = nmag_ff;
      nneg_in = nneg_ff;
      fx_in = fx_ff; fy_in = fy_ff; fp_in = fp_ff;
      fxsq_in = fxsq_ff;
      fysq_in = fysq_ff;
      s_in    = s_ff;
      d_in    = d_ff;
      rv_in   = rv_ff & rsp_stall;
      ox_in = ox_ff; oy_in = oy_ff; op_in = op_ff; opv_in = opv_ff;
      ows_in = ows_ff; owv_in = owv_ff;

      if (csr_valid) begin
         case (csr_index)
            CsrFloor:    floor_in    = csr_data;
            CsrPassthru: passthru_in = csr_data[0];
            CsrRenorm:   renorm_in   = csr_data[0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_opcode)
                  OpScent: begin
                     sx_in  = req_bearing_x;
                     sy_in  = req_bearing_y;
                     spf_in = req_proximity_present;
                     sp_in  = req_proximity_present ? req_proximity : '0;
                  end
                  OpVision: begin
                     vx_in  = req_bearing_x;
                     vy_in  = req_bearing_y;
                     vpf_in = req_proximity_present;
                     vp_in  = req_proximity_present ? req_proximity : '0;
                  end
                  OpTrust: begin
                     ts_in = req_scent_weight;
                     tv_in = req_vision_weight;
                  end
                  default: begin
                     step_in  = StSxx;
                     state_in = ST_ISSUE;
                  end
               endcase
            end
         end

         ST_ISSUE: begin
            state_in = ST_WAIT;
            case (step_ff)
               StDecide: begin
                  ws_in  = ws_w;
                  wv_in  = wv_w;
                  den_in = den_w;
                  pv_in  = passthru_ff & (spf_ff | vpf_ff);
                  if (den_w == '0) begin
                     // fallback: stronger raw bearing, scent wins ties
                     state_in = ST_HOLD;
                     if (ssq_ff >= vsq_ff && ssq_ff != '0) begin
                        fx_in = sx_ff; fy_in = sy_ff; fp_in = sp_ff;
                     end else if (vsq_ff != '0) begin
                        fx_in = vx_ff; fy_in = vy_ff; fp_in = vp_ff;
                     end else begin
                        fx_in = '0; fy_in = '0; fp_in = '0;
                     end
                  end else begin
                     ax_in    = 2'd0;
                     step_in  = StPw1;
                     state_in = ST_ISSUE;
                  end
               end
               StRn: begin
                  if (renorm_ff) begin
                     step_in  = StQx;
                     state_in = ST_ISSUE;
                  end else begin
                     state_in = ST_HOLD;
                  end
               end
               default: begin
               end
            endcase
         end

         ST_WAIT: begin
            if (unit_done) begin
               state_in = ST_ISSUE;
               step_in  = step_ff + 1'b1;
               case (step_ff)
                  StSxx: ssq_in = SqBits'(mul_prod);
                  StSyy: ssq_in = ssq_ff + SqBits'(mul_prod);
                  StVxx: vsq_in = SqBits'(mul_prod);
                  StVyy: vsq_in = vsq_ff + SqBits'(mul_prod);
                  StFll: flsq_in = mul_prod;
                  StPw1: p1_in = mul_prod;
                  StPw2: begin
                     nmag_in = nabs_w[NumBits-2:0];
                     nneg_in = num_w[NumBits-1];
                  end
                  StDw: begin
                     case (ax_ff)
                        2'd0:    fx_in = wsat(div_quo, nneg_ff);
                        2'd1:    fy_in = wsat(div_quo, nneg_ff);
                        default: fp_in = wsat(div_quo, nneg_ff);
                     endcase
                     if (ax_ff != 2'd2) begin
                        ax_in   = ax_ff + 1'b1;
                        step_in = StPw1;
                     end
                  end
                  StQx: fxsq_in = mul_prod;
                  StQy: begin
                     fysq_in = mul_prod;
                     s_in    = s_w[DivDenBits-1:0];
                     ax_in   = 2'd0;
                     if (s_w == '0) begin
                        state_in = ST_HOLD;
                     end
                  end
                  StUd: d_in = div_quo[SqrtInBits-1:0];
                  StUr: begin
                     if (ax_ff[0]) begin
                        fy_in    = rsat_w;
                        state_in = ST_HOLD;
                     end else begin
                        fx_in   = rsat_w;
                        ax_in   = 2'd1;
                        step_in = StUd;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_HOLD: begin
            // hold until the result register is free, then load it
            if (!rv_ff || !rsp_stall) begin
               rv_in    = 1'b1;
               ox_in    = fx_ff;
               oy_in    = fy_ff;
               op_in    = pv_ff ? fp_ff : '0;
               opv_in   = pv_ff;
               ows_in   = ws_ff;
               owv_in   = wv_ff;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         step_ff     <= StSxx;
         ax_ff       <= 2'd0;
         floor_ff    <= FloorBits'(3);
         passthru_ff <= 1'b1;
         renorm_ff   <= 1'b1;
         sx_ff <= '0; sy_ff <= '0; sp_ff <= '0; spf_ff <= 1'b0;
         vx_ff <= '0; vy_ff <= '0; vp_ff <= '0; vpf_ff <= 1'b0;
         ts_ff <= '0; tv_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         step_ff     <= step_in;
         ax_ff       <= ax_in;
         floor_ff    <= floor_in;
         passthru_ff <= passthru_in;
         renorm_ff   <= renorm_in;
         sx_ff <= sx_in; sy_ff <= sy_in; sp_ff <= sp_in; spf_ff <= spf_in;
         vx_ff <= vx_in; vy_ff <= vy_in; vp_ff <= vp_in; vpf_ff <= vpf_in;
         ts_ff <= ts_in; tv_ff <= tv_in;
         rv_ff <= rv_in;
      end
      ssq_ff  <= ssq_in;
      vsq_ff  <= vsq_in;
      flsq_ff <= flsq_in;
      ws_ff   <= ws_in;
      wv_ff   <= wv_in;
      den_ff  <= den_in;
      pv_ff   <= pv_in;
      p1_ff   <= p1_in;
      nmag_ff <= nmag_in;
      nneg_ff <= nneg_in;
      fx_ff   <= fx_in;
      fy_ff   <= fy_in;
      fp_ff   <= fp_in;
      fxsq_ff <= fxsq_in;
      fysq_ff <= fysq_in;
      s_ff    <= s_in;
      d_ff    <= d_in;
      ox_ff   <= ox_in;
      oy_ff   <= oy_in;
      op_ff   <= op_in;
      opv_ff  <= opv_in;
      ows_ff  <= ows_in;
      owv_ff  <= owv_in;
   end

   assign req_stall              = state_ff != ST_IDLE;
   assign csr_ready              = 1'b1;
   assign rsp_valid              = rv_ff;
   assign rsp_fused_x            = ox_ff;
   assign rsp_fused_y            = oy_ff;
   assign rsp_fused_proximity    = op_ff;
   assign rsp_proximity_valid    = opv_ff;
   assign rsp_scent_weight_used  = ows_ff;
   assign rsp_vision_weight_used = owv_ff;

endmodule
